// ===== rtl/csp_pkg.sv =====
// csp_pkg: types and constants for the card section parser
// no dependencies; imported by every rtl file of the block except csp_stream_if
`default_nettype none
package csp_pkg;

	localparam logic [15:0] HEADER_BYTES = 16'd4;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_TITLE  = 2'd2,
		PH_TEXT   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_COUNT     = 3'd1,
		ERR_TRUNC     = 3'd2,
		ERR_LENGTH    = 3'd3,
		ERR_NO_TERM   = 3'd4,
		ERR_TRAILING  = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [12:0] record_length;
		logic        record_start;
	} in_item_t;

	typedef struct packed {
		logic        section_valid;
		logic [7:0]  section_number;
		logic [11:0] title_offset;
		logic [11:0] title_length;
		logic [11:0] text_offset;
		logic [11:0] text_length;
		logic        record_done;
		logic [2:0]  error_code;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/csp_stream_if.sv =====
// csp_stream_if: valid/ready channel carrying one payload struct
// payload type is set per instance; no other dependencies
`default_nettype none
interface csp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/csp_in_reg.sv =====
// csp_in_reg: input register stage of the card section parser
// depends on csp_pkg and csp_stream_if
`default_nettype none
module csp_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	csp_stream_if.sink           rec_in,
	input  wire logic            adv,
	output logic                 valid_s1,
	output csp_pkg::in_item_t    item_s1
);
	import csp_pkg::*;

	logic xfer;

	assign rec_in.ready = !valid_s1 || adv;
	assign xfer = rec_in.valid && rec_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			item_s1 <= rec_in.payload;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/csp_parse_core.sv =====
// csp_parse_core: record parse state and per-byte update logic
// depends on csp_pkg
`default_nettype none
module csp_parse_core #(
	parameter int MAX_SECTIONS = 8,
	parameter int RECORD_BYTES = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire csp_pkg::in_item_t item,
	output logic                   has_res,
	output csp_pkg::out_item_t     res
);
	import csp_pkg::*;

	localparam logic [7:0]  MAX_SEC = 8'(MAX_SECTIONS);
	localparam logic [16:0] REC_MAX = 17'(RECORD_BYTES);

	phase_t      phase_q, phase_d;
	logic [12:0] pos_q, pos_d;
	logic [7:0]  total_q, total_d;
	logic [7:0]  seen_q, seen_d;
	logic [7:0]  hold_q, hold_d;
	logic [15:0] title_q, title_d;
	logic [15:0] text_q, text_d;
	logic [15:0] left_q, left_d;
	logic [11:0] tstart_q, tstart_d;

	logic [12:0] pos_n;
	logic [15:0] left_dec;
	logic [15:0] text_new;
	logic [17:0] span;
	logic [13:0] hdr_end;
	logic [7:0]  seen_inc;
	logic [7:0]  b;
	logic [12:0] len;

	assign b        = item.byte_value;
	assign len      = item.record_length;
	assign pos_n    = pos_q + 13'd1;
	assign left_dec = left_q - 16'd1;
	assign text_new = {b, hold_q};
	assign span     = {5'd0, pos_n} + {2'd0, title_q} + {2'd0, text_new};
	assign hdr_end  = {1'b0, pos_n} + 14'(HEADER_BYTES);
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		total_d  = total_q;
		seen_d   = seen_q;
		hold_d   = hold_q;
		title_d  = title_q;
		text_d   = text_q;
		left_d   = left_q;
		tstart_d = tstart_q;
		has_res  = 1'b0;
		res      = '0;
		res.section_number = seen_q;

		if (fire) begin
			if (item.record_start) begin
				phase_d  = PH_IDLE;
				pos_d    = 13'd1;
				total_d  = '0;
				seen_d   = '0;
				hold_d   = '0;
				title_d  = '0;
				text_d   = '0;
				left_d   = '0;
				tstart_d = '0;
				res.section_number = '0;
				if (len == 13'd0 || {4'd0, len} > REC_MAX) begin
					has_res = 1'b1;
					res.record_done = 1'b1;
					res.error_code = ERR_LENGTH;
				end else if (b == 8'd0 || b > MAX_SEC) begin
					has_res = 1'b1;
					res.record_done = 1'b1;
					res.error_code = ERR_COUNT;
				end else if (len < 13'd5) begin
					has_res = 1'b1;
					res.record_done = 1'b1;
					res.error_code = ERR_TRUNC;
				end else begin
					total_d = b;
					phase_d = PH_HEADER;
					left_d  = HEADER_BYTES;
				end
			end else if (phase_q != PH_IDLE) begin
				pos_d = pos_n;
				unique case (phase_q)
					PH_HEADER: begin
						if (left_q == 16'd4 || left_q == 16'd2) begin
							hold_d = b;
							left_d = left_dec;
						end else if (left_q == 16'd3) begin
							title_d = {b, hold_q};
							left_d  = left_dec;
						end else begin
							text_d = text_new;
							if (title_q == 16'd0 || text_new == 16'd0 ||
							    span > {5'd0, len}) begin
								has_res = 1'b1;
								res.record_done = 1'b1;
								res.error_code = ERR_LENGTH;
								phase_d = PH_IDLE;
							end else begin
								tstart_d = pos_n[11:0];
								phase_d  = PH_TITLE;
								left_d   = title_q;
							end
						end
					end
					PH_TITLE: begin
						left_d = left_dec;
						if (left_dec == 16'd0) begin
							if (b != 8'd0) begin
								has_res = 1'b1;
								res.record_done = 1'b1;
								res.error_code = ERR_NO_TERM;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_TEXT;
								left_d  = text_q;
							end
						end
					end
					PH_TEXT: begin
						left_d = left_dec;
						if (left_dec == 16'd0) begin
							has_res = 1'b1;
							if (b != 8'd0) begin
								res.record_done = 1'b1;
								res.error_code = ERR_NO_TERM;
								phase_d = PH_IDLE;
							end else begin
								res.section_valid = 1'b1;
								res.title_offset  = tstart_q;
								res.title_length  = title_q[11:0];
								res.text_offset   = tstart_q + title_q[11:0];
								res.text_length   = text_q[11:0];
								seen_d = seen_inc;
								if (seen_inc >= total_q) begin
									res.record_done = 1'b1;
									res.error_code = (pos_n != len) ? ERR_TRAILING : ERR_OK;
									phase_d = PH_IDLE;
								end else if (hdr_end > {1'b0, len}) begin
									res.record_done = 1'b1;
									res.error_code = ERR_TRUNC;
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_HEADER;
									left_d  = HEADER_BYTES;
								end
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			total_q  <= '0;
			seen_q   <= '0;
			hold_q   <= '0;
			title_q  <= '0;
			text_q   <= '0;
			left_q   <= '0;
			tstart_q <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			total_q  <= total_d;
			seen_q   <= seen_d;
			hold_q   <= hold_d;
			title_q  <= title_d;
			text_q   <= text_d;
			left_q   <= left_d;
			tstart_q <= tstart_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/csp_out_reg.sv =====
// csp_out_reg: result register driving the section result channel
// depends on csp_pkg and csp_stream_if
`default_nettype none
module csp_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_valid,
	input  wire csp_pkg::out_item_t load_item,
	output logic                    adv,
	csp_stream_if.source            res_out
);
	import csp_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	assign adv             = !valid_q || res_out.ready;
	assign res_out.valid   = valid_q;
	assign res_out.payload = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && load_valid) begin
			item_q <= load_item;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/card_section_parser.sv =====
// card_section_parser: streaming layout check of one card record, one byte per transfer
// a result enters the result register as the byte causing it leaves the input register
// throughput: one byte per cycle while results is not stalled, set by the combinational
// parse update between the input register and the result register
// reset: arst_n clears all parse state to idle and empties both registers
`default_nettype none
module card_section_parser #(
	parameter int MAX_SECTIONS = 8,
	parameter int RECORD_BYTES = 4096
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	csp_stream_if.sink   rec_bytes,
	csp_stream_if.source results
);
	import csp_pkg::*;

	logic      adv;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      fire;
	logic      has_res;
	out_item_t res;

	assign fire = valid_s1 && adv;

	csp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_in   (rec_bytes),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	csp_parse_core #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.RECORD_BYTES (RECORD_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.has_res (has_res),
		.res     (res)
	);

	csp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (fire && has_res),
		.load_item  (res),
		.adv        (adv),
		.res_out    (results)
	);
endmodule
`default_nettype wire

// ===== rtl/csp_checker.sv =====
// csp_checker: port-level checks on the result channel of card_section_parser
// depends on csp_pkg; bound to the top level below
`default_nettype none
module csp_port_checks (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire csp_pkg::out_item_t out_item
);
	import csp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_code_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.record_done |-> out_item.error_code == ERR_OK)
		else $error("error code without record done");

	a_result_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.section_valid || out_item.record_done)
		else $error("result with neither section nor status");

	a_section_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.section_valid |->
			out_item.title_length != 12'd0 && out_item.text_length != 12'd0)
		else $error("section with empty string");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.error_code <= ERR_TRAILING)
		else $error("error code out of range");
endmodule

bind card_section_parser csp_port_checks u_csp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_item  (results.payload)
);
`default_nettype wire
